[rtl/core/fnvh_pkg.sv]
package fnvh_pkg;

	localparam logic [31:0] HASH_BASIS = 32'h811c_9dc5;
	localparam logic [31:0] HASH_PRIME = 32'h0100_0193;
	localparam int unsigned HASH_WIDTH = 32;
	localparam int unsigned FOLD_WIDTH = 5;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic       has_byte;
		logic       last;
		logic [7:0] data_byte;
	} fnvh_entry_t;

	typedef struct packed {
		logic        valid;
		fnvh_entry_t entry;
	} fnvh_head_t;

	function automatic logic [HASH_WIDTH-1:0] fold_hash(
		input logic [HASH_WIDTH-1:0] h,
		input logic [FOLD_WIDTH-1:0] k
	);
		logic [HASH_WIDTH-1:0] mask;
		logic [FOLD_WIDTH:0]   shamt;
		mask  = (HASH_WIDTH'(1) << k) - HASH_WIDTH'(1);
		shamt = (FOLD_WIDTH+1)'(HASH_WIDTH) - {1'b0, k};
		if (k == '0) begin
			return h;
		end
		return (h >> shamt) ^ (h & mask);
	endfunction

endpackage

[rtl/core/fnv1a32_stream_hash_fold_unit.sv]
// FNV-1a 32-bit byte-stream hash. One byte per item enters on s_axis
// (tuser set when tdata carries a byte, tlast closing the message); the
// closing item yields one 32-bit hash on m_axis, xor-folded to fold_bits
// bits when fold_bits is nonzero, upper bits zero. Sustained rate is one
// item per clock cycle while m_axis keeps taking results, set by the
// xor-and-prime-multiply loop on the running hash register. A 4-entry
// queue separates the input side from the hash engine; a closing item
// passes the queue, engine result register and fold output register.
// fold_bits is written through cfg_valid/cfg_data and is always ready.
module fnv1a32_stream_hash_fold_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,      // fold_bits
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // carries_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // hash_value
);

	fnvh_pkg::fnvh_entry_t in_entry;
	fnvh_pkg::fnvh_head_t  head;
	logic                  pop;
	logic                  res_valid;
	logic [31:0]           res_hash;
	logic                  res_ready;
	logic [4:0]            fold_bits_q;
	logic                  out_valid_q;
	logic [31:0]           out_data_q;

	assign in_entry.has_byte  = s_axis_tuser;
	assign in_entry.last      = s_axis_tlast;
	assign in_entry.data_byte = s_axis_tdata;

	fnvh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_entry (in_entry),
		.head     (head),
		.pop      (pop)
	);

	fnvh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_hash  (res_hash),
		.res_ready (res_ready)
	);

	assign cfg_ready     = 1'b1;
	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= fnvh_pkg::fold_hash(res_hash, fold_bits_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_bits_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				fold_bits_q <= cfg_data;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

endmodule

[rtl/core/fnvh_front.sv]
module fnvh_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fnvh_pkg::fnvh_entry_t in_entry,
	output fnvh_pkg::fnvh_head_t  head,
	input  logic               pop
);

	fnvh_pkg::fnvh_entry_t mem_q [fnvh_pkg::QUEUE_DEPTH];
	logic [fnvh_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [fnvh_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [fnvh_pkg::QUEUE_AW:0]   count_q;
	logic                          push;
	logic                          do_pop;

	assign in_ready = (count_q != (fnvh_pkg::QUEUE_AW+1)'(fnvh_pkg::QUEUE_DEPTH));
	// items with no byte that do not close a message are dropped here
	assign push     = in_valid && in_ready && (in_entry.has_byte || in_entry.last);
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/fnvh_back.sv]
module fnvh_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fnvh_pkg::fnvh_head_t head,
	output logic                 pop,
	output logic                 res_valid,
	output logic [31:0]          res_hash,
	input  logic                 res_ready
);

	logic [31:0] hash_q;
	logic [31:0] hash_next;
	logic [31:0] mixed;
	logic        res_valid_s1;
	logic [31:0] res_hash_s1;
	logic        slot_free;

	assign mixed     = hash_q ^ {24'd0, head.entry.data_byte};
	assign hash_next = head.entry.has_byte ? (mixed * fnvh_pkg::HASH_PRIME) : hash_q;
	assign slot_free = !res_valid_s1 || res_ready;
	assign pop       = head.valid && (!head.entry.last || slot_free);

	assign res_valid = res_valid_s1;
	assign res_hash  = res_hash_s1;

	always_ff @(posedge clk) begin
		if (pop && head.entry.last) begin
			res_hash_s1 <= hash_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q       <= fnvh_pkg::HASH_BASIS;
			res_valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				hash_q <= head.entry.last ? fnvh_pkg::HASH_BASIS : hash_next;
			end
			if (pop && head.entry.last) begin
				res_valid_s1 <= 1'b1;
			end else if (res_ready) begin
				res_valid_s1 <= 1'b0;
			end
		end
	end

endmodule

[tb/fnv1a32_stream_hash_fold_checker.sv]
`timescale 1ns / 1ps

module fnv1a32_stream_hash_fold_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,      // fold_bits
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // carries_byte
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // hash_value
	output int          mismatches,
	output int          hashes_due
);

	localparam logic [31:0] FNV_OFFSET = 32'h811c_9dc5;
	localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

	logic [31:0] hash_acc;
	logic [4:0]  fold_width;
	logic [31:0] hash_q[$];

	function automatic logic [31:0] absorb_byte(input logic [31:0] h, input logic [7:0] b);
		return (h ^ {24'd0, b}) * FNV_PRIME;
	endfunction

	function automatic logic [31:0] fold_down(input logic [31:0] h, input logic [4:0] k);
		logic [31:0] low_mask;
		if (k == 5'd0) begin
			return h;
		end
		low_mask = (32'd1 << k) - 32'd1;
		return (h >> (6'd32 - {1'b0, k})) ^ (h & low_mask);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns hash check: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			hash_acc = FNV_OFFSET;
			fold_width = 5'd0;
			hash_q.delete();
			mismatches = 0;
			hashes_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fold_width = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (hash_q.size() == 0) begin
					report_mismatch($sformatf("unexpected hash_value %08h", m_axis_tdata));
				end else begin
					want = hash_q.pop_front();
					if (m_axis_tdata !== want) begin
						report_mismatch($sformatf("hash_value %08h, expected %08h",
							m_axis_tdata, want));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) begin
					hash_acc = absorb_byte(hash_acc, s_axis_tdata);
				end
				if (s_axis_tlast) begin
					hash_q.push_back(fold_down(hash_acc, fold_width));
					hash_acc = FNV_OFFSET;
				end
			end
			hashes_due <= hash_q.size();
		end
	end

endmodule

[tb/fnv1a32_stream_hash_fold_unit_tb.sv]
`timescale 1ns / 1ps

module fnv1a32_stream_hash_fold_unit_tb;

	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_ITEMS  = 200;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data      = 5'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;  // data_byte
	logic        s_axis_tuser  = 1'b0;  // carries_byte
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // hash_value

	int mismatches;
	int hashes_due;
	int send_idle    = 0;
	int recv_stall   = 0;
	int hold_request = 0;
	int hold_left    = 0;
	int items_sent   = 0;
	int cycle_count  = 0;

	fnv1a32_stream_hash_fold_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	fnv1a32_stream_hash_fold_checker hash_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.hashes_due   (hashes_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic has_byte, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= has_byte;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (has_byte || fin) begin
			items_sent++;
		end
	endtask

	task automatic send_message(input int len);
		bit byte_close;
		byte_close = (len > 0) && ($urandom_range(9) < 7);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0);
			end
			send_item(8'($urandom), 1'b1, byte_close && (i == len - 1));
		end
		if (!byte_close) begin
			send_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (hashes_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_fold(input logic [4:0] k);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [4:0] fold_plan [8];
		int phase_start;
		int len;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fold width still at its reset value
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b1);
		send_item(8'h12, 1'b1, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);
		send_item(8'h34, 1'b1, 1'b0);
		send_item(8'haa, 1'b0, 1'b1);
		send_item(8'hde, 1'b1, 1'b0);
		send_item(8'had, 1'b1, 1'b0);
		send_item(8'hbe, 1'b1, 1'b0);
		send_item(8'hef, 1'b1, 1'b1);

		set_fold(5'd31);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b1);
		send_item(8'h01, 1'b1, 1'b1);
		set_fold(5'd1);
		send_item(8'h7f, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);

		// fold width changed between the bytes of one message
		set_fold(5'd16);
		send_item(8'h5a, 1'b1, 1'b0);
		set_fold(5'd8);
		send_item(8'ha5, 1'b1, 1'b1);

		fold_plan = '{5'd0, 5'd31, 5'd1, 5'($urandom_range(30, 2)),
			5'd16, 5'd31, 5'd0, 5'($urandom_range(31, 1))};

		for (int ph = 0; ph < 8; ph++) begin
			set_fold(fold_plan[ph]);
			case (ph % 4)
				0: begin
					send_idle = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle = 82;
					recv_stall = 0;
				end
				2: begin
					send_idle = 0;
					recv_stall = 82;
				end
				default: begin
					send_idle = 8;
					recv_stall = 8;
				end
			endcase
			phase_start = items_sent;
			if (ph == 4) begin
				// long receiver hold-off while short messages keep coming
				hold_request = 150;
				while (items_sent < phase_start + 60) begin
					send_message($urandom_range(3, 0));
				end
				phase_start = items_sent;
			end
			while (items_sent < phase_start + PHASE_ITEMS) begin
				if ($urandom_range(19) == 0) begin
					send_item(8'($urandom), 1'($urandom), 1'($urandom));
				end else begin
					len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 0);
					send_message(len);
				end
			end
		end

		wait_drained();
		if (mismatches == 0 && hashes_due == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[fnv1a32_stream_hash_fold_unit.f]
rtl/core/fnvh_pkg.sv
rtl/core/fnvh_front.sv
rtl/core/fnvh_back.sv
rtl/core/fnv1a32_stream_hash_fold_unit.sv
tb/fnv1a32_stream_hash_fold_checker.sv
tb/fnv1a32_stream_hash_fold_unit_tb.sv
